### hdl/cmsa_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the cone
// midpoint steering block. No dependencies.
package cmsa_pkg;

    // Point coordinate width and derived datapath widths.
    localparam int COORD_BITS  = 16;
    localparam int SUM_W       = COORD_BITS + 1;
    localparam int SQ_W        = 2 * COORD_BITS + 1;
    localparam int THR_W       = 15;
    localparam int LIM_W       = 2 * THR_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int XY_W        = SUM_W + 19;
    localparam int ACC_W       = 33;
    localparam int ANG_W       = ACC_W - 16;
    localparam int THETA_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int PROD_W      = THETA_W + GAIN_W + 1;
    localparam int STEER_W     = 24;
    localparam int TAB_LEN     = 24;
    localparam int TAB_IDX_W   = $clog2(TAB_LEN);
    localparam int TAB_W       = 30;
    localparam int CORDIC_STEPS_DEF = 16;

    // Configuration port.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register reset values.
    localparam logic signed [15:0]      HEIGHT_SPLIT_RST = -16'sd1400;
    localparam logic [THR_W-1:0]        DIST_THR_RST     = 15'd1000;
    localparam logic signed [15:0]      FAR_LIMIT_RST    = 16'sd10000;
    localparam logic [GAIN_W-1:0]       STEER_GAIN_RST   = 16'd256;

    // Register indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_HEIGHT_SPLIT = 2'd0,
        REG_DIST_THR     = 2'd1,
        REG_FAR_LIMIT    = 2'd2,
        REG_STEER_GAIN   = 2'd3
    } reg_idx_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_STEER = 2'd0,
        STAT_FAR   = 2'd1,
        STAT_NONE  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK,
        ST_ROT_INIT,
        ST_ROTATE,
        ST_ROUND,
        ST_SCALE,
        ST_EMIT
    } state_t;

    // Payload of one input transaction.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic                         last_point;
    } point_t;

    // Payload of one output transaction.
    typedef struct packed {
        logic signed [STEER_W-1:0] steer_value;
        logic [1:0]                result_status;
    } result_t;

    // Configuration register values.
    typedef struct packed {
        logic signed [15:0]  height_split;
        logic [THR_W-1:0]    distance_threshold;
        logic signed [15:0]  far_height_limit;
        logic [GAIN_W-1:0]   steer_gain;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_point;
        logic    clear_cloud;
        logic    square;
        logic    rot_init;
        logic    rot_step;
        logic    round_angle;
        logic    scale;
        logic    load_out;
        status_t out_code;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_point;
        logic far_point;
        logic dist_gt;
        logic rot_last;
        logic out_busy;
    } dp_status_t;

    // atan(2^-i) in centidegrees scaled by 2^16, rounded.
    function automatic logic [TAB_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic [TAB_W-1:0] val;
        case (idx)
            5'd0:    val = 30'd294912000;
            5'd1:    val = 30'd174096719;
            5'd2:    val = 30'd91987925;
            5'd3:    val = 30'd46694507;
            5'd4:    val = 30'd23437865;
            5'd5:    val = 30'd11730358;
            5'd6:    val = 30'd5866610;
            5'd7:    val = 30'd2933484;
            5'd8:    val = 30'd1466764;
            5'd9:    val = 30'd733385;
            5'd10:   val = 30'd366693;
            5'd11:   val = 30'd183347;
            5'd12:   val = 30'd91673;
            5'd13:   val = 30'd45837;
            5'd14:   val = 30'd22918;
            5'd15:   val = 30'd11459;
            5'd16:   val = 30'd5730;
            5'd17:   val = 30'd2865;
            5'd18:   val = 30'd1432;
            5'd19:   val = 30'd716;
            5'd20:   val = 30'd358;
            5'd21:   val = 30'd179;
            5'd22:   val = 30'd90;
            5'd23:   val = 30'd45;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### hdl/cmsa_regs.sv
// Configuration register file with an APB-style write and read port.
// Depends on cmsa_pkg for the register indexes, reset values and cfg_t.
module cmsa_regs
    import cmsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes at the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.height_split       <= HEIGHT_SPLIT_RST;
            cfg_reg.distance_threshold <= DIST_THR_RST;
            cfg_reg.far_height_limit   <= FAR_LIMIT_RST;
            cfg_reg.steer_gain         <= STEER_GAIN_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_HEIGHT_SPLIT: cfg_reg.height_split       <= pwdata[15:0];
                REG_DIST_THR:     cfg_reg.distance_threshold <= pwdata[THR_W-1:0];
                REG_FAR_LIMIT:    cfg_reg.far_height_limit   <= pwdata[15:0];
                REG_STEER_GAIN:   cfg_reg.steer_gain         <= pwdata[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        case (idx)
            REG_HEIGHT_SPLIT: prdata = {16'd0, cfg_reg.height_split};
            REG_DIST_THR:     prdata = {17'd0, cfg_reg.distance_threshold};
            REG_FAR_LIMIT:    prdata = {16'd0, cfg_reg.far_height_limit};
            REG_STEER_GAIN:   prdata = {16'd0, cfg_reg.steer_gain};
            default:          prdata = '0;
        endcase
    end

endmodule

### hdl/cmsa_ctrl.sv
// Controller state machine: sequences the distance test, the CORDIC
// iterations and the result hand-off. Depends on cmsa_pkg.
module cmsa_ctrl
    import cmsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       point_valid,
    input  logic       point_last,
    output logic       point_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    cloud_done_reg, cloud_done_next;

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            code_reg       <= STAT_NONE;
            cloud_done_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            code_reg       <= code_next;
            cloud_done_reg <= cloud_done_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next      = state_reg;
        code_next       = code_reg;
        cloud_done_next = cloud_done_reg;
        point_stall     = 1'b1;
        cmd             = '0;
        cmd.out_code    = code_reg;

        case (state_reg)
            ST_IDLE:
            begin
                point_stall = 1'b0;
                if (point_valid)
                begin
                    if (cloud_done_reg)
                    begin
                        // The rest of a finished cloud is dropped.
                        if (point_last)
                        begin
                            cmd.clear_cloud = 1'b1;
                            cloud_done_next = 1'b0;
                        end
                    end
                    else
                    begin
                        cmd.load_point = 1'b1;
                        state_next     = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.dist_gt)
                begin
                    if (status.far_point)
                    begin
                        code_next  = STAT_FAR;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        code_next  = STAT_STEER;
                        state_next = ST_ROT_INIT;
                    end
                end
                else if (status.last_point)
                begin
                    code_next  = STAT_NONE;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROT_INIT:
            begin
                cmd.rot_init = 1'b1;
                state_next   = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                cmd.rot_step = 1'b1;
                if (status.rot_last)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round_angle = 1'b1;
                state_next      = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Wait until the output register can take the result.
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                    if (status.last_point)
                    begin
                        cmd.clear_cloud = 1'b1;
                        cloud_done_next = 1'b0;
                    end
                    else
                    begin
                        cloud_done_next = (code_reg != STAT_NONE);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/cmsa_dpath.sv
// Datapath: stored cone points, midpoint distance test, CORDIC atan2,
// gain scaling and the output register. Depends on cmsa_pkg.
module cmsa_dpath
    import cmsa_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  point_t     point,
    input  cfg_t       cfg,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic signed [ACC_W-1:0] ROT90 = ACC_W'(589824000);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);
    localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(18000);
    localparam logic signed [ANG_W-1:0] ANG_MIN = -ANG_W'(18000);
    localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(9000);
    localparam logic signed [PROD_W-1:0] OUT_RND = PROD_W'(128);

    // Stored points and per-point flags.
    logic signed [COORD_BITS-1:0] left_x_reg, left_y_reg, right_x_reg, right_y_reg;
    logic signed [SUM_W-1:0]      sum_x_reg, sum_y_reg;
    logic                         far_reg, last_reg;
    logic [SQ_W-1:0]              sq_x_reg, sq_y_reg;
    logic [LIM_W-1:0]             lim_reg;

    // CORDIC and scaling registers.
    logic signed [XY_W-1:0]       cx_reg, cy_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic [STEP_W-1:0]            step_reg;
    logic signed [THETA_W-1:0]    theta_reg;
    logic signed [PROD_W-1:0]     prod_reg;

    // Output register.
    logic                         out_valid_reg;
    result_t                      out_data_reg;

    logic                         is_left, is_right;
    logic signed [COORD_BITS-1:0] new_lx, new_ly, new_rx, new_ry;
    logic signed [2*SUM_W-1:0]    prod_sx, prod_sy;
    logic [DIST_W-1:0]            dist2, lim4;
    logic signed [XY_W-1:0]       sx_w, sy_w, dx, dy;
    logic signed [ACC_W-1:0]      tab_val, acc_rnd;
    logic signed [ANG_W-1:0]      ang, ang_clamp, theta_full;
    logic signed [GAIN_W:0]       gain_s;
    logic signed [PROD_W-1:0]     prod_next, steer_rnd;

    // Left/right selection and the midpoint sums of the updated points.
    assign is_left  = point.point_z < cfg.height_split;
    assign is_right = point.point_z > cfg.height_split;
    assign new_lx   = is_left  ? point.point_x : left_x_reg;
    assign new_ly   = is_left  ? point.point_y : left_y_reg;
    assign new_rx   = is_right ? point.point_x : right_x_reg;
    assign new_ry   = is_right ? point.point_y : right_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_x_reg  <= '0;
            left_y_reg  <= '0;
            right_x_reg <= '0;
            right_y_reg <= '0;
        end
        else if (cmd.clear_cloud)
        begin
            left_x_reg  <= '0;
            left_y_reg  <= '0;
            right_x_reg <= '0;
            right_y_reg <= '0;
        end
        else if (cmd.load_point)
        begin
            left_x_reg  <= new_lx;
            left_y_reg  <= new_ly;
            right_x_reg <= new_rx;
            right_y_reg <= new_ry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_point)
        begin
            sum_x_reg <= {new_lx[COORD_BITS-1], new_lx} + {new_rx[COORD_BITS-1], new_rx};
            sum_y_reg <= {new_ly[COORD_BITS-1], new_ly} + {new_ry[COORD_BITS-1], new_ry};
            far_reg   <= point.point_z >= cfg.far_height_limit;
            last_reg  <= point.last_point;
        end
    end

    // Squares of the doubled midpoint and of the threshold.
    assign prod_sx = sum_x_reg * sum_x_reg;
    assign prod_sy = sum_y_reg * sum_y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            sq_x_reg <= prod_sx[SQ_W-1:0];
            sq_y_reg <= prod_sy[SQ_W-1:0];
            lim_reg  <= cfg.distance_threshold * cfg.distance_threshold;
        end
    end

    // Distance test against four times the squared threshold.
    assign dist2 = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign lim4  = {{(DIST_W - LIM_W - 2){1'b0}}, lim_reg, 2'b00};

    // CORDIC vectoring, one iteration a cycle.
    assign sx_w    = {{(XY_W - SUM_W - 16){sum_x_reg[SUM_W-1]}}, sum_x_reg, 16'd0};
    assign sy_w    = {{(XY_W - SUM_W - 16){sum_y_reg[SUM_W-1]}}, sum_y_reg, 16'd0};
    assign dx      = cy_reg >>> step_reg;
    assign dy      = cx_reg >>> step_reg;
    assign tab_val = signed'({{(ACC_W - TAB_W){1'b0}},
                             atan_entry(TAB_IDX_W'(step_reg))});

    always_ff @(posedge clk)
    begin
        if (cmd.rot_init)
        begin
            step_reg <= '0;
            if (sum_x_reg < 0)
            begin
                // Turn a left-half vector by a quarter turn first.
                if (sum_y_reg >= 0)
                begin
                    cx_reg  <= sy_w;
                    cy_reg  <= -sx_w;
                    acc_reg <= ROT90;
                end
                else
                begin
                    cx_reg  <= -sy_w;
                    cy_reg  <= sx_w;
                    acc_reg <= -ROT90;
                end
            end
            else
            begin
                cx_reg  <= sx_w;
                cy_reg  <= sy_w;
                acc_reg <= '0;
            end
        end
        else if (cmd.rot_step)
        begin
            step_reg <= step_reg + 1'b1;
            if (cy_reg > 0)
            begin
                cx_reg  <= cx_reg + dx;
                cy_reg  <= cy_reg - dy;
                acc_reg <= acc_reg + tab_val;
            end
            else
            begin
                cx_reg  <= cx_reg - dx;
                cy_reg  <= cy_reg + dy;
                acc_reg <= acc_reg - tab_val;
            end
        end
    end

    // Round to centidegrees, clamp, and form the steering angle.
    assign acc_rnd    = acc_reg + RND_HALF;
    assign ang        = acc_rnd[ACC_W-1:16];
    assign ang_clamp  = (ang > ANG_MAX) ? ANG_MAX : ((ang < ANG_MIN) ? ANG_MIN : ang);
    assign theta_full = -QUARTER - ang_clamp;

    // Gain product and its rounding.
    assign gain_s    = signed'({1'b0, cfg.steer_gain});
    assign prod_next = theta_reg * gain_s;
    assign steer_rnd = prod_reg + OUT_RND;

    always_ff @(posedge clk)
    begin
        if (cmd.round_angle)
        begin
            theta_reg <= theta_full[THETA_W-1:0];
        end
        if (cmd.scale)
        begin
            prod_reg <= prod_next;
        end
    end

    // Output register: holds a transaction until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg.result_status <= cmd.out_code;
            if (cmd.out_code == STAT_STEER)
            begin
                out_data_reg.steer_value <= steer_rnd[STEER_W+7:8];
            end
            else
            begin
                out_data_reg.steer_value <= '0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Status back to the controller.
    assign status.last_point = last_reg;
    assign status.far_point  = far_reg;
    assign status.dist_gt    = dist2 > lim4;
    assign status.rot_last   = step_reg == STEP_LAST;
    assign status.out_busy   = out_valid_reg && result_stall;

endmodule

### hdl/cone_midpoint_steer_angle.sv
// Cone midpoint steering angle. Each point is accepted, squared and then
// distance-tested; points of a cloud after its result are taken 1 per cycle.
// A steering result passes the check, CORDIC init, iterate, round and scale
// states into the output register; the CORDIC loop iterates one step a cycle.
// Reset (rst_n, asynchronous, active low) restores the register defaults and
// clears the stored points; no clearing pass is needed.
module cone_midpoint_steer_angle
    import cmsa_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              point_valid,
    output logic              point_stall,
    input  point_t            point,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Configuration registers.
    cmsa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    cmsa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_last  (point.last_point),
        .point_stall (point_stall),
        .status      (status),
        .cmd         (cmd)
    );

    // Arithmetic and output register.
    cmsa_dpath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .point        (point),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
